// ----- src/lcdn_pkg.sv -----
// lcdn_pkg: word types, operation codes and init table for the lcd nibble sequencer
// no dependencies; imported by lcdn_bcd_conv and char_lcd_nibble_sequencer_core
`default_nettype none

package lcdn_pkg;

    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] bus_nibble;
        logic       enable_pin;
        logic [4:0] hold_ms;
        logic       last;
    } pin_word_t;

    // status from the binary to bcd converter
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [19:0] digits;
    } bcd_stat_t;

    localparam logic [1:0] OP_INIT = 2'd0;
    localparam logic [1:0] OP_CMD  = 2'd1;
    localparam logic [1:0] OP_DATA = 2'd2;
    localparam logic [1:0] OP_NUM  = 2'd3;

    localparam logic [7:0] ASCII_ZERO     = 8'd48;
    localparam logic [4:0] HOLD_STEP      = 5'd1;
    localparam logic [4:0] HOLD_INIT_WAIT = 5'd4;
    localparam logic [4:0] HOLD_INIT_END  = 5'd20;
    localparam logic [3:0] INIT_WAIT_CNT  = 4'd3;
    localparam logic [3:0] INIT_LAST_IDX  = 4'd8;

    function automatic logic [7:0] init_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h03;
            4'd1:    b = 8'h03;
            4'd2:    b = 8'h03;
            4'd3:    b = 8'h02;
            4'd4:    b = 8'h28;
            4'd5:    b = 8'h08;
            4'd6:    b = 8'h01;
            4'd7:    b = 8'h06;
            4'd8:    b = 8'h0C;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- src/char_lcd_nibble_sequencer_core.sv -----
// char_lcd_nibble_sequencer_core: turns init/command/data/number requests into
// 4-bit lcd bus steps; depends on lcdn_pkg and lcdn_bcd_conv
//
//  channel | signals                          | direction | word
//  cmd     | cmd_valid, cmd_ready, cmd_word   | in        | operation, value
//  pin     | pin_valid, pin_ready, pin_word   | out       | rs, nibble, enable, hold, last
//
// an idle cycle takes a request, then one pin word per cycle while pin_ready stays high:
// 4 words for command and data, 40 for init; a number is first converted (16 shifts,
// then the digits are counted), then 4 words per digit
// cmd_ready is high only between requests; a pending pin word does not block a new request
// reset clears the sequencer and the output valid; stalls on pin hold the word in place
`default_nettype none

module char_lcd_nibble_sequencer_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    output      logic                cmd_ready,
    input  wire lcdn_pkg::cmd_word_t cmd_word,
    output      logic                pin_valid,
    input  wire logic                pin_ready,
    output      lcdn_pkg::pin_word_t pin_word
);
    import lcdn_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_t;

    state_t      state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic [7:0]  byte_reg, byte_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [1:0]  phase_reg, phase_next;
    logic        extra_reg, extra_next;
    logic [2:0]  nd_reg, nd_next;
    logic        pin_valid_reg, pin_valid_next;
    pin_word_t   pin_word_reg, pin_word_next;

    bcd_stat_t   bcd_stat;
    logic        bcd_start;
    logic        load;
    logic        is_last_byte;
    logic [2:0]  dig_idx;
    logic [3:0]  digit;
    logic [7:0]  cur_byte;

    lcdn_bcd_conv u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bcd_start),
        .bin   (cmd_word.value),
        .stat  (bcd_stat)
    );

    assign cmd_ready = (state_reg == S_IDLE);
    assign bcd_start = cmd_valid && cmd_ready && (cmd_word.operation == OP_NUM);
    assign load      = (state_reg == S_EMIT) && (!pin_valid_reg || pin_ready);

    // digits go out most significant first
    assign dig_idx = nd_reg - 3'd1 - cnt_reg[2:0];

    always_comb
    begin
        case (dig_idx)
            3'd0:    digit = bcd_stat.digits[3:0];
            3'd1:    digit = bcd_stat.digits[7:4];
            3'd2:    digit = bcd_stat.digits[11:8];
            3'd3:    digit = bcd_stat.digits[15:12];
            3'd4:    digit = bcd_stat.digits[19:16];
            default: digit = 4'd0;
        endcase
    end

    always_comb
    begin
        case (op_reg)
            OP_INIT: cur_byte = init_byte(cnt_reg);
            OP_NUM:  cur_byte = ASCII_ZERO + {4'd0, digit};
            default: cur_byte = byte_reg;
        endcase
    end

    always_comb
    begin
        if (op_reg == OP_NUM)
            is_last_byte = (cnt_reg[2:0] == nd_reg - 3'd1);
        else
            is_last_byte = 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        byte_next      = byte_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        extra_next     = extra_reg;
        nd_next        = nd_reg;
        pin_valid_next = pin_valid_reg;
        pin_word_next  = pin_word_reg;

        if (pin_valid_reg && pin_ready)
            pin_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next    = cmd_word.operation;
                    byte_next  = cmd_word.value[7:0];
                    cnt_next   = 4'd0;
                    phase_next = 2'd0;
                    extra_next = 1'b0;
                    state_next = (cmd_word.operation == OP_NUM) ? S_CONV : S_EMIT;
                end
            end
            S_CONV:
            begin
                if (bcd_stat.done)
                begin
                    // zero still gives one digit
                    if (bcd_stat.digits[19:16] != 4'd0)
                        nd_next = 3'd5;
                    else if (bcd_stat.digits[15:12] != 4'd0)
                        nd_next = 3'd4;
                    else if (bcd_stat.digits[11:8] != 4'd0)
                        nd_next = 3'd3;
                    else if (bcd_stat.digits[7:4] != 4'd0)
                        nd_next = 3'd2;
                    else
                        nd_next = 3'd1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (load)
                begin
                    pin_valid_next           = 1'b1;
                    pin_word_next.reg_select = (op_reg == OP_DATA) || (op_reg == OP_NUM);
                    if (extra_reg)
                    begin
                        // init wait step repeats the low nibble with enable low
                        pin_word_next.bus_nibble = cur_byte[3:0];
                        pin_word_next.enable_pin = 1'b0;
                        extra_next               = 1'b0;
                        phase_next               = 2'd0;
                        cnt_next                 = cnt_reg + 4'd1;
                        if (cnt_reg == INIT_LAST_IDX)
                        begin
                            pin_word_next.hold_ms = HOLD_INIT_END;
                            pin_word_next.last    = 1'b1;
                            state_next            = S_IDLE;
                        end
                        else
                        begin
                            pin_word_next.hold_ms = HOLD_INIT_WAIT;
                            pin_word_next.last    = 1'b0;
                        end
                    end
                    else
                    begin
                        pin_word_next.bus_nibble = phase_reg[1] ? cur_byte[3:0] : cur_byte[7:4];
                        pin_word_next.enable_pin = ~phase_reg[0];
                        pin_word_next.hold_ms    = HOLD_STEP;
                        pin_word_next.last       = 1'b0;
                        phase_next               = phase_reg + 2'd1;
                        if (phase_reg == 2'd3)
                        begin
                            if (op_reg == OP_INIT)
                            begin
                                if (cnt_reg < INIT_WAIT_CNT || cnt_reg == INIT_LAST_IDX)
                                    extra_next = 1'b1;
                                else
                                    cnt_next = cnt_reg + 4'd1;
                            end
                            else if (is_last_byte)
                            begin
                                pin_word_next.last = 1'b1;
                                state_next         = S_IDLE;
                            end
                            else
                                cnt_next = cnt_reg + 4'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 4'd0;
            phase_reg     <= 2'd0;
            extra_reg     <= 1'b0;
            nd_reg        <= 3'd1;
            op_reg        <= OP_INIT;
            byte_reg      <= 8'd0;
            pin_valid_reg <= 1'b0;
            pin_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            extra_reg     <= extra_next;
            nd_reg        <= nd_next;
            op_reg        <= op_next;
            byte_reg      <= byte_next;
            pin_valid_reg <= pin_valid_next;
            pin_word_reg  <= pin_word_next;
        end
    end

    assign pin_valid = pin_valid_reg;
    assign pin_word  = pin_word_reg;

endmodule

`default_nettype wire

// ----- src/lcdn_bcd_conv.sv -----
// lcdn_bcd_conv: 16-bit binary to five bcd digits, one shift-and-correct step per cycle
// depends on lcdn_pkg
`default_nettype none

module lcdn_bcd_conv (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [15:0]        bin,
    output lcdn_pkg::bcd_stat_t     stat
);
    import lcdn_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [19:0] bcd_reg, bcd_next;
    logic [15:0] bin_reg, bin_next;
    logic [19:0] adj;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        bcd_next  = bcd_reg;
        bin_next  = bin_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
            bcd_next  = 20'd0;
            bin_next  = bin;
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[18:0], bin_reg[15]};
            bin_next = {bin_reg[14:0], 1'b0};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    assign stat = {busy_reg, done_reg, bcd_reg};

endmodule

`default_nettype wire
